[src/cpal_pkg.sv]
// Shared types, widths, register indexes and the cosine table generator for the
// cosine palette pixel generator. No dependencies.
`default_nettype none

package cpal_pkg;

    // Field and datapath widths
    localparam int COL_W      = 12;   // column index
    localparam int STEP_W     = 24;   // column step, unsigned Q0.24
    localparam int T_W        = COL_W + STEP_W;  // t, unsigned Q12.24
    localparam int COEF_W     = 16;   // one coefficient, signed Q2.14
    localparam int FRAC_W     = 38;   // fractional phase bits
    localparam int SUM_W      = 33;   // a*2^14 + b*cos
    localparam int ACC_W      = SUM_W + 8;  // times 255
    localparam int LEVEL_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RED   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GREEN = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_BLUE  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_STEP  = CFG_IDX_W'(3);

    // Reset values: a = b = d = 0.5, c = 0.25; step about 0.001
    localparam logic [CFG_DATA_W-1:0] COEF_RESET = 64'h2000_1000_2000_2000;
    localparam logic [STEP_W-1:0]     STEP_RESET = 24'd16777;

    // Pipeline stage positions
    localparam int NUM_STAGES = 6;
    localparam int STG_T      = 0;
    localparam int STG_FRAC   = 1;
    localparam int STG_IDX    = 2;
    localparam int STG_COS    = 3;
    localparam int STG_SUM    = 4;
    localparam int STG_LEVEL  = 5;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;   // stage register takes a new request
    } pipe_ctrl_t;

    // Table generator constants (Q2.30)
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
    localparam longint      ONE_Q30    = 64'sd1073741824;

    // Horner step divides by den * 2^30: drop 30 bits, then an exact reciprocal
    // multiply. Dividend stays below 2^32 and den below 2^9, so a 41-bit scale
    // with a rounded-up reciprocal gives the floor quotient.
    localparam int          RCP_SHIFT = 41;
    localparam logic [63:0] RCP_380 = 64'(((128'd1 << RCP_SHIFT) + 128'd379) / 128'd380);
    localparam logic [63:0] RCP_306 = 64'(((128'd1 << RCP_SHIFT) + 128'd305) / 128'd306);
    localparam logic [63:0] RCP_240 = 64'(((128'd1 << RCP_SHIFT) + 128'd239) / 128'd240);
    localparam logic [63:0] RCP_182 = 64'(((128'd1 << RCP_SHIFT) + 128'd181) / 128'd182);
    localparam logic [63:0] RCP_132 = 64'(((128'd1 << RCP_SHIFT) + 128'd131) / 128'd132);
    localparam logic [63:0] RCP_90  = 64'(((128'd1 << RCP_SHIFT) + 128'd89) / 128'd90);
    localparam logic [63:0] RCP_56  = 64'(((128'd1 << RCP_SHIFT) + 128'd55) / 128'd56);
    localparam logic [63:0] RCP_30  = 64'(((128'd1 << RCP_SHIFT) + 128'd29) / 128'd30);
    localparam logic [63:0] RCP_12  = 64'(((128'd1 << RCP_SHIFT) + 128'd11) / 128'd12);
    localparam logic [63:0] RCP_2   = 64'(((128'd1 << RCP_SHIFT) + 128'd1) / 128'd2);

    // floor(num / (den * 2^30)); num is never negative here
    function automatic longint horner_div(input longint num, input logic [63:0] rcp);
        logic [63:0]  y;
        logic [127:0] prod;
        y    = 64'(num) >> 30;
        prod = 128'(y) * 128'(rcp);
        return longint'(prod[RCP_SHIFT +: 64]);
    endfunction

    // Cosine table entry for u = k * 2^32 / size; Q2.14, rounded.
    // Quadrant folding, then a ten term Horner Taylor series in Q2.30.
    function automatic logic signed [COEF_W-1:0] cos_entry(input logic [63:0] u_in);
        logic [63:0] u;
        logic [63:0] theta;
        logic [63:0] sq;
        logic        neg;
        longint      x2;
        longint      r;
        longint      v;
        u   = u_in;
        neg = 1'b0;
        if (u > (64'd1 << 31)) begin
            u = (64'd1 << 32) - u;
        end
        if (u > (64'd1 << 30)) begin
            u   = (64'd1 << 31) - u;
            neg = 1'b1;
        end
        theta = (u * TWO_PI_Q30) >> 32;
        sq    = (theta * theta) >> 30;
        x2    = longint'(sq);
        r     = ONE_Q30;
        r = ONE_Q30 - horner_div(x2 * r, RCP_380);
        r = ONE_Q30 - horner_div(x2 * r, RCP_306);
        r = ONE_Q30 - horner_div(x2 * r, RCP_240);
        r = ONE_Q30 - horner_div(x2 * r, RCP_182);
        r = ONE_Q30 - horner_div(x2 * r, RCP_132);
        r = ONE_Q30 - horner_div(x2 * r, RCP_90);
        r = ONE_Q30 - horner_div(x2 * r, RCP_56);
        r = ONE_Q30 - horner_div(x2 * r, RCP_30);
        r = ONE_Q30 - horner_div(x2 * r, RCP_12);
        r = ONE_Q30 - horner_div(x2 * r, RCP_2);
        if (r < 0) begin
            r = 0;
        end
        v = (r + 64'sd32768) >>> 16;
        if (neg) begin
            v = -v;
        end
        return COEF_W'(v);
    endfunction

endpackage

`default_nettype wire

[src/cpal_pipe_ctrl.sv]
// Valid bits and per-stage load enables of the palette pipeline.
// Depends on cpal_pkg.
`default_nettype none

module cpal_pipe_ctrl import cpal_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output pipe_ctrl_t      ctrl
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES:0]   ready;

    // A stage is free when empty or when its request moves on this cycle
    always_comb begin
        ready[NUM_STAGES] = m_tready;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (k == 0) begin
                ctrl.load[k] = s_tvalid && ready[k];
            end else begin
                ctrl.load[k] = valid_reg[k-1] && ready[k];
            end
            valid_next[k] = ctrl.load[k] || (valid_reg[k] && !ready[k+1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = ready[0];
    assign m_tvalid = valid_reg[NUM_STAGES-1];

endmodule

`default_nettype wire

[src/cpal_channel.sv]
// One colour channel: phase, table index, cosine ROM, blend and saturation.
// Depends on cpal_pkg; load enables come from cpal_pipe_ctrl.
`default_nettype none

module cpal_channel import cpal_pkg::*; #(
    parameter int COS_TABLE_SIZE = 1024
) (
    input  wire logic                  aclk,
    input  wire pipe_ctrl_t            ctrl,
    input  wire logic [CFG_DATA_W-1:0] coef,
    input  wire logic [T_W-1:0]        t,
    output logic      [LEVEL_W-1:0]    level
);

    localparam int IDX_W  = (COS_TABLE_SIZE > 1) ? $clog2(COS_TABLE_SIZE) : 1;
    localparam int NMUL_W = IDX_W + 1;
    localparam int SCL_W  = FRAC_W + NMUL_W;
    localparam int CT_W   = COEF_W + T_W + 1;

    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
    logic        [COEF_W-1:0] coef_d;

    assign coef_a = coef[COEF_W-1:0];
    assign coef_b = coef[2*COEF_W-1:COEF_W];
    assign coef_c = coef[3*COEF_W-1:2*COEF_W];
    assign coef_d = coef[4*COEF_W-1:3*COEF_W];

    // Cosine ROM, one period, built at elaboration
    logic signed [COEF_W-1:0] cos_rom [COS_TABLE_SIZE];

    for (genvar k = 0; k < COS_TABLE_SIZE; k++) begin : g_rom
        localparam logic [63:0] U = (64'(k) << 32) / COS_TABLE_SIZE;
        localparam logic signed [COEF_W-1:0] V = cos_entry(U);
        assign cos_rom[k] = V;
    end

    // Phase: c*t + d*2^24, kept modulo 2^38 (floor fraction)
    logic signed [CT_W-1:0]   ct_full;
    logic        [FRAC_W-1:0] frac_next;
    logic        [FRAC_W-1:0] frac_reg;

    assign ct_full   = coef_c * $signed({1'b0, t});
    assign frac_next = ct_full[FRAC_W-1:0] + {coef_d[FRAC_W-25:0], 24'b0};

    // Table index: (frac * size) >> 38
    logic [SCL_W-1:0] scaled;
    logic [IDX_W-1:0] idx_reg;

    assign scaled = SCL_W'(frac_reg) * SCL_W'(COS_TABLE_SIZE);

    // Blend and scale
    logic signed [COEF_W-1:0]   cos_reg;
    logic signed [2*COEF_W-1:0] bc;
    logic signed [SUM_W-1:0]    sum_next;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [ACC_W-1:0]    acc;
    logic        [11:0]         quot;
    logic        [LEVEL_W-1:0]  level_next;
    logic        [LEVEL_W-1:0]  level_reg;

    assign bc       = coef_b * cos_reg;
    assign sum_next = $signed({{(SUM_W-COEF_W-14){coef_a[COEF_W-1]}}, coef_a, 14'b0})
                    + SUM_W'(bc);
    assign acc      = (ACC_W'(sum_reg) <<< 8) - ACC_W'(sum_reg);
    assign quot     = acc[39:28];

    // Negative clamps to 0 (truncation toward zero gives 0 or less), big to 255
    always_comb begin
        if (sum_reg < 0) begin
            level_next = '0;
        end else if (quot > 12'd255) begin
            level_next = '1;
        end else begin
            level_next = quot[LEVEL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[STG_FRAC]) begin
            frac_reg <= frac_next;
        end
        if (ctrl.load[STG_IDX]) begin
            idx_reg <= scaled[FRAC_W +: IDX_W];
        end
        if (ctrl.load[STG_COS]) begin
            cos_reg <= cos_rom[idx_reg];
        end
        if (ctrl.load[STG_SUM]) begin
            sum_reg <= sum_next;
        end
        if (ctrl.load[STG_LEVEL]) begin
            level_reg <= level_next;
        end
    end

    assign level = level_reg;

endmodule

`default_nettype wire

[src/cosine_palette_pixel_gen_unit.sv]
// Pipeline: a request passes six register stages, the first loaded at the edge
// that accepts it; m_tvalid rises when it reaches the last.
// Throughput: one request per cycle unless stalled; six pipeline stages with a
// valid bit each, and a stalled output lets earlier stages fill their bubbles.
// Reset (aresetn low, synchronous): all valid bits cleared, registers back to
// their defaults (a = b = d = 0.5, c = 0.25, step about 0.001). No clearing pass.
`default_nettype none

module cosine_palette_pixel_gen_unit import cpal_pkg::*; #(
    parameter int MAX_WIDTH      = 4096,
    parameter int COS_TABLE_SIZE = 1024
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // input requests
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,   // [11:0] column_index, [15:12] zero
    // result requests
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [23:0]                m_tdata    // [7:0] red, [15:8] green, [23:16] blue
);

    // Highest column the palette sees; larger indexes clamp to it
    localparam int COL_FULL = (1 << COL_W) - 1;
    localparam int COL_MAX  = (MAX_WIDTH - 1 > COL_FULL) ? COL_FULL : MAX_WIDTH - 1;
    localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(COL_MAX);

    // ---------------------------------------------------------------------
    // Configuration registers. The user must write them only while the pipeline is
    // empty (the block does not enforce it), so the stages read them directly.
    // ---------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] red_coef_reg;
    logic [CFG_DATA_W-1:0] green_coef_reg;
    logic [CFG_DATA_W-1:0] blue_coef_reg;
    logic [STEP_W-1:0]     step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_coef_reg   <= COEF_RESET;
            green_coef_reg <= COEF_RESET;
            blue_coef_reg  <= COEF_RESET;
            step_reg       <= STEP_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_RED: begin
                    red_coef_reg <= cfg_wdata;
                end
                REG_GREEN: begin
                    green_coef_reg <= cfg_wdata;
                end
                REG_BLUE: begin
                    blue_coef_reg <= cfg_wdata;
                end
                REG_STEP: begin
                    step_reg <= cfg_wdata[STEP_W-1:0];  // upper bits dropped
                end
                default: begin
                    // index past the register list: write ignored
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Pipeline control: valid bits and load enables
    // ---------------------------------------------------------------------
    pipe_ctrl_t ctrl;

    cpal_pipe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctrl     (ctrl)
    );

    // ---------------------------------------------------------------------
    // Stage 1: clamp the column and form t = column * step (Q12.24),
    // shared by all three channels
    // ---------------------------------------------------------------------
    logic [COL_W-1:0] column;
    logic [T_W-1:0]   t_reg;

    always_comb begin
        column = s_tdata[COL_W-1:0];
        if (column > COL_LIMIT) begin
            column = COL_LIMIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[STG_T]) begin
            t_reg <= T_W'(column) * T_W'(step_reg);
        end
    end

    // ---------------------------------------------------------------------
    // Stages 2 to 6, one lane per colour
    // ---------------------------------------------------------------------
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;

    cpal_channel #(.COS_TABLE_SIZE(COS_TABLE_SIZE)) u_red (
        .aclk  (aclk),
        .ctrl  (ctrl),
        .coef  (red_coef_reg),
        .t     (t_reg),
        .level (red_level)
    );

    cpal_channel #(.COS_TABLE_SIZE(COS_TABLE_SIZE)) u_green (
        .aclk  (aclk),
        .ctrl  (ctrl),
        .coef  (green_coef_reg),
        .t     (t_reg),
        .level (green_level)
    );

    cpal_channel #(.COS_TABLE_SIZE(COS_TABLE_SIZE)) u_blue (
        .aclk  (aclk),
        .ctrl  (ctrl),
        .coef  (blue_coef_reg),
        .t     (t_reg),
        .level (blue_level)
    );

    assign m_tdata = {blue_level, green_level, red_level};

endmodule

`default_nettype wire

[src/cpal_checker.sv]
// Port-level checks on the palette generator, bound to the top level.
// Depends on cosine_palette_pixel_gen_unit.
`default_nettype none

module cpal_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    // a held result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result request dropped while stalled");

    // a held result keeps its colour
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // pipeline is empty after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered straight after reset");

    // with the sink taking, every stage can move, so input is never held off
    a_no_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output is free");

endmodule

bind cosine_palette_pixel_gen_unit cpal_checker u_checker (.*);

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for cosine_palette_pixel_gen_unit: streams column indexes through the block
// and checks every RGB result against a scoreboard with its own fixed-point palette model.
// Depends on cpal_pkg (widths, register indexes) and the unit under test.

module tb_top;
    import cpal_pkg::*;

    // ------------------------------------------------------------------
    // Run shape
    // ------------------------------------------------------------------
    localparam int CLK_HALF        = 6;     // 12 ns period
    localparam int RESET_CYCLES    = 11;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_ITEMS     = 80;    // 8 x 80 + 24 directed, 664 requests
    localparam int HOLD_OFF_CYCLES = 300;   // long receiver stall, fills the pipeline
    localparam int DRAIN_CYCLES    = 12;    // pipeline is 6 deep, some margin
    localparam int IDLE_LIMIT      = 2000;  // cycles with no handshake before giving up

    // Palette arithmetic constants
    localparam int          COS_ENTRIES = 1024;
    localparam logic [63:0] ANGLE_2PI   = 64'd6746518852;   // 2*pi in Q2.30
    localparam longint      UNIT_Q30    = 64'sd1073741824;
    localparam longint      LEVEL_SCALE = 64'sd268435456;   // 2^28

    // One result request; red sits in the low byte of m_tdata
    typedef struct packed {
        bit [7:0] blue_level;
        bit [7:0] green_level;
        bit [7:0] red_level;
    } pixel_t;

    // ------------------------------------------------------------------
    // Scoreboard: palette registers, cosine table and the expected colours
    // ------------------------------------------------------------------
    class palette_scoreboard;
        bit [63:0] coefs [3];              // red, green, blue: a,b,c,d Q2.14 from bit 0
        bit [23:0] step;                   // Q0.24
        int        cos_table [COS_ENTRIES];
        pixel_t    expected_pixels [$];
        int        errors;

        function new();
            bit [63:0] u;
            bit [63:0] theta;
            bit        neg;
            longint    v;
            coefs  = '{64'h2000_1000_2000_2000, 64'h2000_1000_2000_2000,
                       64'h2000_1000_2000_2000};
            step   = 24'd16777;
            errors = 0;
            // one period of cosine, folded onto the first quadrant
            for (int k = 0; k < COS_ENTRIES; k++) begin
                u   = (64'(k) << 32) / COS_ENTRIES;
                neg = 1'b0;
                if (u > (64'd1 << 31))
                    u = (64'd1 << 32) - u;
                if (u > (64'd1 << 30)) begin
                    u   = (64'd1 << 31) - u;
                    neg = 1'b1;
                end
                theta = (u * ANGLE_2PI) >> 32;
                v = (quarter_cosine(theta) + 64'sd32768) >>> 16;
                cos_table[k] = int'(neg ? -v : v);
            end
        endfunction

        // Taylor series in Horner form, Q2.30 in and out
        function longint quarter_cosine(bit [63:0] theta);
            bit [63:0] sq;
            longint    x2;
            longint    r;
            longint    den;
            sq = (theta * theta) >> 30;
            x2 = longint'(sq);
            r  = UNIT_Q30;
            for (int n = 10; n >= 1; n--) begin
                den = (2 * n - 1) * (2 * n);
                r   = UNIT_Q30 - (x2 * r) / (den * UNIT_Q30);
            end
            if (r < 0)
                r = 0;
            return r;
        endfunction

        function bit [7:0] predict_level(bit [63:0] cw, bit [35:0] t);
            shortint   a, b, c, d;
            bit [63:0] cx, dx, phase;
            bit [9:0]  slot;
            longint    acc, q;
            a  = cw[15:0];
            b  = cw[31:16];
            c  = cw[47:32];
            d  = cw[63:48];
            cx = longint'(c);
            dx = longint'(d);
            phase = cx * t + (dx << 24);
            slot  = phase[37:28];          // top bits of the 38-bit fraction
            acc = (longint'(a) * 16384 + longint'(b) * cos_table[slot]) * 255;
            q   = acc / LEVEL_SCALE;       // truncates toward zero
            if (q < 0)
                q = 0;
            if (q > 255)
                q = 255;
            return q[7:0];
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, bit [63:0] value);
            case (idx)
                REG_RED:   coefs[0] = value;
                REG_GREEN: coefs[1] = value;
                REG_BLUE:  coefs[2] = value;
                REG_STEP:  step = value[23:0];
                default: ;                 // spare indexes do nothing
            endcase
        endfunction

        // a 12-bit column can never pass the width limit, so no clamp here
        function void note_column(bit [11:0] col);
            bit [35:0] t;
            pixel_t    px;
            t = col * step;
            px.red_level   = predict_level(coefs[0], t);
            px.green_level = predict_level(coefs[1], t);
            px.blue_level  = predict_level(coefs[2], t);
            expected_pixels.push_back(px);
        endfunction

        function void check_pixel(bit [23:0] word);
            pixel_t got, want;
            got = word;
            if (expected_pixels.size() == 0) begin
                $error("result %h with no request outstanding", word);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            if (got.red_level != want.red_level) begin
                $error("red_level: expected %0d, got %0d", want.red_level, got.red_level);
                errors++;
            end
            if (got.green_level != want.green_level) begin
                $error("green_level: expected %0d, got %0d", want.green_level,
                       got.green_level);
                errors++;
            end
            if (got.blue_level != want.blue_level) begin
                $error("blue_level: expected %0d, got %0d", want.blue_level, got.blue_level);
                errors++;
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Signals; every input known from time zero
    // ------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;   // [11:0] column_index, [15:12] zero
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [23:0]           m_tdata;          // [7:0] red, [15:8] green, [23:16] blue

    palette_scoreboard palette = new();

    // idling controls, shared between the stimulus and the receiver
    bit quiet_tx         = 1'b0;   // sender offers back to back
    bit quiet_rx         = 1'b0;   // receiver always ready
    bit hold_off_request = 1'b0;   // one long receiver stall, taken by the receiver

    int idle_cycles = 0;

    // directed columns: extremes, alternating bit patterns, quadrant edges
    bit [11:0] directed_columns [24] = '{
        12'd0,    12'd1,    12'd2,    12'd4095, 12'd4094, 12'h800, 12'hAAA, 12'h555,
        12'd0,    12'd4095, 12'd1,    12'h800,  12'h3FF,  12'hC00, 12'd7,   12'hFF0,
        12'd0,    12'd4095, 12'h400,  12'h200,  12'h100,  12'hFFF, 12'h001, 12'h7FF
    };

    always #CLK_HALF aclk = ~aclk;

    cosine_palette_pixel_gen_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // ------------------------------------------------------------------
    // Monitor: note each accepted request before checking the result of
    // the same edge. Values read here are the ones the block sampled.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                palette.note_column(s_tdata[11:0]);
            if (m_tvalid && m_tready)
                palette.check_pixel(m_tdata);
        end
    end

    // Watchdog: counts cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, mostly short stalls, now and then a
    // long one; a hold-off request gives one very long stall.
    // ------------------------------------------------------------------
    initial begin : receiver
        bit level;
        int span;
        int r;
        forever begin
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                level = 1'b0;
                span  = HOLD_OFF_CYCLES;
            end else if (quiet_rx) begin
                level = 1'b1;
                span  = 1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    level = 1'b1;
                    span  = $urandom_range(1, 8);
                end else if (r < 95) begin
                    level = 1'b0;
                    span  = $urandom_range(1, 3);
                end else begin
                    level = 1'b0;
                    span  = $urandom_range(20, 60);
                end
            end
            m_tready <= level;
            repeat (span) @(posedge aclk);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int sender_gap();
        int r;
        if (quiet_tx)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic bit [11:0] pick_column();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 12'd0;
        if (r == 1)
            return 12'd4095;
        return 12'($urandom_range(0, 4095));
    endfunction

    // coefficients mostly in a range that gives visible gradients,
    // sometimes any 16-bit pattern
    function automatic bit [63:0] random_coefs();
        bit [63:0] w;
        for (int i = 0; i < 4; i++) begin
            if ($urandom_range(0, 3) == 0)
                w[16*i +: 16] = 16'($urandom);
            else
                w[16*i +: 16] = 16'(int'($urandom_range(0, 24575)) - 8192);
        end
        return w;
    endfunction

    function automatic bit [63:0] random_step();
        case ($urandom_range(0, 3))
            0:       return {$urandom, $urandom};           // upper bits dropped
            1:       return 64'($urandom_range(0, 65535));
            2:       return 64'($urandom_range(0, 24'hFF_FFFF));
            default: return 64'd16777 * $urandom_range(1, 40);
        endcase
    endfunction

    // one request; the valid stays up when no gap follows
    task automatic send_column(input bit [11:0] col);
        int gap;
        s_tdata  <= {4'b0000, col};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        gap = sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // stop offering and wait until every result is back; the first edge lets
    // the monitor note a request accepted at the edge just passed
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (palette.pending() != 0)
            @(posedge aclk);
    endtask

    // write enable stays high across a burst; the caller lowers it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        palette.write_register(idx, value);
    endtask

    task automatic load_palette(input bit [63:0] red, input bit [63:0] green,
                                input bit [63:0] blue, input bit [63:0] step_word,
                                input bit poke_spare);
        write_reg(REG_RED, red);
        write_reg(REG_GREEN, green);
        write_reg(REG_BLUE, blue);
        write_reg(REG_STEP, step_word);
        // unused indexes, with all ones, must change nothing
        if (poke_spare)
            for (int j = int'(REG_STEP) + 1; j < (1 << CFG_IDX_W); j++)
                write_reg(CFG_IDX_W'(j), '1);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset palette, then saturating and clamping palettes
        for (int i = 0; i < 24; i++) begin
            if (i == 8) begin
                drain_results();
                // red: a = b = max -> above 255; green: a = b = min -> below 0;
                // blue: all ones; step word with junk above bit 23
                load_palette(64'h0000_0000_7FFF_7FFF, 64'h0000_0000_8000_8000,
                             64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FF00_4000, 1'b1);
            end
            if (i == 16) begin
                drain_results();
                // largest step, extreme coefficients, blue swinging through both clamps
                load_palette(64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000,
                             64'h0000_4000_4000_2000, 64'h0000_0000_00FF_FFFF, 1'b0);
            end
            send_column(directed_columns[i]);
        end

        // Random phases, each with a fresh palette
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain_results();
            quiet_tx = (p % 3 == 1);
            quiet_rx = quiet_tx;
            load_palette(random_coefs(), random_coefs(), random_coefs(), random_step(),
                         p == 0);
            if (p == 2) begin
                // receiver stalls for a long time while requests keep coming
                hold_off_request = 1'b1;
                quiet_tx         = 1'b1;
            end
            repeat (PHASE_ITEMS)
                send_column(pick_column());
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (palette.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
